>>> design/decimal_hex_integer_parser_core_defines.svh
// Assertion macros for the decimal/hex integer parser.
// Depends on nothing; taken in by the checker file only.
`ifndef DECIMAL_HEX_INTEGER_PARSER_CORE_DEFINES_SVH
`define DECIMAL_HEX_INTEGER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define DHIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define DHIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dhip_pkg.sv
// Shared types, codes and character helpers for the decimal/hex integer parser.
// Depends on nothing; imported by every module of the block.
package dhip_pkg;

    typedef logic [2:0] t_kind;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NO_DIGITS      = 3'd1,
        ST_OVERFLOW       = 3'd2,
        ST_TRAILING       = 3'd3,
        ST_MINUS_UNSIGNED = 3'd4
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_result;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [5:0] DIGIT_NONE = 6'd63;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;

    // Mask of the kind's width: bits 2:1 of the kind select 8, 16, 32 or 64 bits.
    function automatic logic [63:0] kind_mask(input t_kind k);
        logic [63:0] m;
        case (k[2:1])
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Largest magnitude allowed; a negative signed value may reach one past the maximum.
    function automatic logic [63:0] kind_limit(input t_kind k, input logic neg);
        logic [63:0] m;
        logic [63:0] lim;
        m = kind_mask(k);
        if (k[0]) begin
            lim = m;
        end else if (neg) begin
            lim = (m >> 1) + 64'd1;
        end else begin
            lim = m >> 1;
        end
        return lim;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Digit value of 0-9, A-Z, a-z; anything else gives DIGIT_NONE.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = {2'b00, DIGIT_NONE};
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c - CH_ZERO;
        end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            v = c - CH_UP_A + 8'd10;
        end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
            v = c - CH_LO_A + 8'd10;
        end
        return v[5:0];
    endfunction

endpackage

>>> design/decimal_hex_integer_parser_core.sv
// Streaming string-to-integer parser: one character per transfer, one result per string.
// A NUL passes from the input register through the parse step into the result register, which drives m_tvalid.
// Throughput: one character per cycle while no NUL waits on a full result register, set by the
// single pass of the digit step (shift-add by 10 or 16 and the limit compare) after the input register.
// Reset (i_rst_n low, synchronous) empties both registers and rearms the parser.
// Depends on dhip_pkg, dhip_in_reg, dhip_parse and dhip_out_reg.
module decimal_hex_integer_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [2:0]  s_tuser,   // [2:0] target_kind
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [2:0]  m_tuser    // [2:0] status
);
    import dhip_pkg::*;

    t_item   item_in;
    t_item   item_q;
    logic    item_valid;
    logic    parse_ready;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result res_q;

    // The character and the target kind travel together; the kind only matters
    // on the first character of a string, where the parser samples it.
    assign item_in.ch   = s_tdata;
    assign item_in.kind = s_tuser;

    // Input register: a new character is taken while it is empty or whenever the held one moves on.
    dhip_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (item_in),
        .o_valid (item_valid),
        .o_item  (item_q),
        .i_ready (parse_ready)
    );

    // Parsing step. Ordinary characters always move on; only the NUL, which
    // carries a result, waits for room in the result register.
    dhip_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item_q),
        .o_ready     (parse_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Result register: while a result waits, the following string parses on up to its NUL.
    dhip_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_tvalid),
        .o_res   (res_q),
        .i_ready (m_tready)
    );

    assign m_tdata = res_q.value;
    assign m_tuser = res_q.status;

endmodule

>>> design/dhip_in_reg.sv
// Input register stage of the parser: holds one accepted character.
// Depends on dhip_pkg.
module dhip_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dhip_pkg::t_item i_item,
    output logic          o_valid,
    output dhip_pkg::t_item o_item,
    input  logic          i_ready
);
    import dhip_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/dhip_parse.sv
// Parsing state and the per-character step: leading whitespace, sign, prefix, digit accumulation
// with an exact limit check, and the result on the terminating NUL.
// Depends on dhip_pkg.
module dhip_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dhip_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_res_valid,
    output dhip_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import dhip_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_WS,
        PH_SIGNED,
        PH_ZERO,
        PH_ZEROX,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    t_kind       r_kind, n_kind;
    logic        r_neg, n_neg;
    logic        r_hex, n_hex;
    logic        r_digit, n_digit;
    logic        r_ovf, n_ovf;
    t_status     r_err, n_err;

    logic        fire;
    logic        is_nul;
    t_kind       kind_eff;
    logic [5:0]  dval;
    logic        step_hex;
    logic [63:0] step_acc;
    logic        base_ok;
    logic [67:0] mul;
    logic [68:0] prod;
    logic [63:0] lim;
    logic        fits;
    t_status     stop_err;
    t_status     st;
    logic [63:0] sval;

    // Digit step (take a digit or stop the scan), shared by several phases.
    t_phase      td_phase;
    logic [63:0] td_acc;
    logic        td_ovf;
    logic        td_digit;
    t_status     td_err;

    assign is_nul      = (i_item.ch == CH_NUL);
    assign o_ready     = !is_nul || i_res_ready;
    assign fire        = i_valid && o_ready;
    assign o_res_valid = i_valid && is_nul;

    always_comb begin
        kind_eff = (r_phase == PH_START) ? i_item.kind : r_kind;
        dval     = digit_value(i_item.ch);
        // After "0x" the accumulator restarts in base 16.
        step_hex = r_hex || (r_phase == PH_ZEROX);
        step_acc = (r_phase == PH_ZEROX) ? 64'd0 : r_acc;
        base_ok  = step_hex ? (dval < BASE_HEX) : (dval < BASE_DEC);
        mul      = step_hex ? {step_acc, 4'b0000}
                            : ({1'b0, step_acc, 3'b000} + {3'b000, step_acc, 1'b0});
        prod     = {1'b0, mul} + {63'd0, dval};
        lim      = kind_limit(kind_eff, r_neg);
        fits     = (prod <= {5'd0, lim});
        stop_err = r_ovf ? ST_OVERFLOW : (!r_digit ? ST_NO_DIGITS : ST_TRAILING);

        td_acc   = r_acc;
        td_ovf   = r_ovf;
        td_digit = r_digit;
        td_err   = r_err;
        if (!base_ok) begin
            td_phase = PH_STOP;
            td_err   = stop_err;
        end else begin
            td_phase = PH_DIGITS;
            if (r_ovf || !fits) begin
                td_ovf = 1'b1;
            end else begin
                td_acc   = prod[63:0];
                td_digit = 1'b1;
            end
        end
    end

    // Result of the terminating NUL.
    always_comb begin
        case (r_phase)
            PH_ZERO, PH_DIGITS: st = r_ovf ? ST_OVERFLOW : (r_digit ? ST_OK : ST_NO_DIGITS);
            PH_ZEROX:           st = ST_TRAILING;
            PH_STOP:            st = r_err;
            default:            st = ST_NO_DIGITS;
        endcase
        sval = r_neg ? (64'd0 - r_acc) : r_acc;
        o_res.status = st;
        o_res.value  = ((st == ST_OK) || (st == ST_TRAILING))
                       ? (sval & kind_mask(kind_eff)) : 64'd0;
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_kind  = kind_eff;
        n_neg   = r_neg;
        n_hex   = r_hex;
        n_digit = r_digit;
        n_ovf   = r_ovf;
        n_err   = r_err;
        if (is_nul) begin
            n_phase = PH_START;
            n_acc   = 64'd0;
            n_neg   = 1'b0;
            n_hex   = 1'b0;
            n_digit = 1'b0;
            n_ovf   = 1'b0;
            n_err   = ST_OK;
        end else begin
            unique case (r_phase)
                PH_START, PH_WS, PH_SIGNED: begin
                    if ((r_phase != PH_SIGNED) && is_ws(i_item.ch)) begin
                        n_phase = PH_WS;
                    end else if ((r_phase != PH_SIGNED) && (i_item.ch == CH_MINUS)) begin
                        if (kind_eff[0]) begin
                            n_phase = PH_STOP;
                            n_err   = ST_MINUS_UNSIGNED;
                        end else begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGNED;
                        end
                    end else if ((r_phase != PH_SIGNED) && (i_item.ch == CH_PLUS)) begin
                        n_phase = PH_SIGNED;
                    end else if (i_item.ch == CH_ZERO) begin
                        n_digit = 1'b1;
                        n_acc   = 64'd0;
                        n_phase = PH_ZERO;
                    end else begin
                        n_phase = td_phase;
                        n_acc   = td_acc;
                        n_ovf   = td_ovf;
                        n_digit = td_digit;
                        n_err   = td_err;
                    end
                end
                PH_ZERO: begin
                    if ((i_item.ch == CH_LO_X) || (i_item.ch == CH_UP_X)) begin
                        n_phase = PH_ZEROX;
                    end else begin
                        n_phase = td_phase;
                        n_acc   = td_acc;
                        n_ovf   = td_ovf;
                        n_digit = td_digit;
                        n_err   = td_err;
                    end
                end
                PH_ZEROX, PH_DIGITS: begin
                    if ((r_phase == PH_ZEROX) && base_ok) begin
                        n_hex = 1'b1;
                    end
                    n_phase = td_phase;
                    n_acc   = td_acc;
                    n_ovf   = td_ovf;
                    n_digit = td_digit;
                    n_err   = td_err;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= 64'd0;
            r_kind  <= 3'd0;
            r_neg   <= 1'b0;
            r_hex   <= 1'b0;
            r_digit <= 1'b0;
            r_ovf   <= 1'b0;
            r_err   <= ST_OK;
        end else if (fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_kind  <= n_kind;
            r_neg   <= n_neg;
            r_hex   <= n_hex;
            r_digit <= n_digit;
            r_ovf   <= n_ovf;
            r_err   <= n_err;
        end
    end

endmodule

>>> design/dhip_out_reg.sv
// Result register of the parser: holds one finished result until it is taken.
// Depends on dhip_pkg.
module dhip_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dhip_pkg::t_result i_res,
    output logic              o_valid,
    output dhip_pkg::t_result o_res,
    input  logic              i_ready
);
    import dhip_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

endmodule

>>> design/dhip_checker.sv
// Port-level checks for the decimal/hex integer parser, bound to the top level.
// Depends on dhip_pkg and decimal_hex_integer_parser_core_defines.svh.
`include "decimal_hex_integer_parser_core_defines.svh"

module dhip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import dhip_pkg::*;

    // A stalled result keeps its value and status.
    `DHIP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Failures other than trailing characters report a zero value.
    `DHIP_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, m_tvalid && (m_tuser == ST_NO_DIGITS || m_tuser == ST_OVERFLOW || m_tuser == ST_MINUS_UNSIGNED), m_tdata == 64'd0, "failed parse with non-zero value")

    // Only the five defined status codes leave the block.
    `DHIP_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_tvalid, m_tuser <= ST_MINUS_UNSIGNED, "undefined status code")

    // Straight after reset both registers are empty.
    `DHIP_ASSERT_NOW(a_after_reset, i_clk, i_rst_n, $past(!i_rst_n), s_tready && !m_tvalid, "registers not empty after reset")

endmodule

bind decimal_hex_integer_parser_core dhip_checker u_dhip_checker (.*);
